[rtl/core/unique_color_palette_builder_defines.svh]
// Assertion macros for the unique colour palette builder
`ifndef UNIQUE_COLOR_PALETTE_BUILDER_DEFINES_SVH
`define UNIQUE_COLOR_PALETTE_BUILDER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define UCPB_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("palette builder check failed");

// next-cycle implication, checked out of reset
`define UCPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("palette builder check failed");

`endif

[rtl/core/ucpb_pkg.sv]
// Shared types and constants for the unique colour palette builder
package ucpb_pkg;

  localparam int unsigned PALETTE_ENTRIES_DEF = 256;
  localparam int unsigned QUEUE_DEPTH         = 2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       first_pixel;
    logic       last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] color_index;
    logic       is_new;
    logic       overflowed;
    logic [8:0] color_count;
    logic       image_done;
    logic       build_failed;
  } out_item_t;

  typedef struct packed {
    logic [23:0] colour;
    logic        first;
    logic        last;
  } pix_t;

endpackage

[rtl/core/unique_color_palette_builder.sv]
// Top level of the unique colour palette builder
//
//   channel   direction  handshake           payload
//   in_       input      in_valid/in_stall   in_item   (pixel, first/last marks)
//   out_      output     out_valid/out_stall out_item  (index, flags, count)
//
// A pixel goes from the queue head through the scan to the result register;
// the palette memory has one read port and is scanned one entry a cycle.
// Reset clears the count and overflow state; palette entries are not cleared.
// A two-transaction queue takes pixels while the scanner works.
// A stalled result holds in the output register; the scanner waits behind it.
`include "unique_color_palette_builder_defines.svh"

module unique_color_palette_builder #(
  parameter int unsigned PALETTE_ENTRIES = ucpb_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ucpb_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ucpb_pkg::out_item_t out_item
);
  import ucpb_pkg::*;

  logic       q_valid;
  logic       q_pop;
  pix_t       q_pix;
  logic [7:0] new_idx;

  assign new_idx = 8'(out_item.color_count - 9'd1);

  ucpb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pix    (q_pix),
    .q_pop    (q_pop)
  );

  ucpb_scan #(
    .ENTRIES(PALETTE_ENTRIES)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pix     (q_pix),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  `UCPB_ASSERT_IMPLY(a_new_not_overflowed, out_valid && out_item.is_new, !out_item.overflowed)
  `UCPB_ASSERT_IMPLY(a_count_bound, out_valid, out_item.color_count <= 9'(PALETTE_ENTRIES))
  `UCPB_ASSERT_IMPLY(a_new_index, out_valid && out_item.is_new, out_item.color_index == new_idx)
  `UCPB_ASSERT_IMPLY(a_fail_on_last, out_valid && out_item.build_failed, out_item.image_done)
  `UCPB_ASSERT_NEXT(a_pop_nonempty, q_pop, !in_stall)

endmodule

[rtl/core/ucpb_queue.sv]
// Front end: accepts pixels, packs the colour and queues them for the scanner
module ucpb_queue #(
  parameter int unsigned DEPTH = ucpb_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ucpb_pkg::in_item_t in_item,
  output logic              q_valid,
  output ucpb_pkg::pix_t    q_pix,
  input  logic              q_pop
);
  import ucpb_pkg::*;

  localparam int unsigned PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNW = $clog2(DEPTH + 1);

  pix_t           buf_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           push;
  pix_t           pix_in;

  assign in_stall = (cnt_r == CNW'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_pix    = buf_r[rd_ptr_r];

  assign pix_in.colour = {in_item.red, in_item.green, in_item.blue};
  assign pix_in.first  = in_item.first_pixel;
  assign pix_in.last   = in_item.last_pixel;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + CNW'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - CNW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= pix_in;
    end
  end

endmodule

[rtl/core/ucpb_scan.sv]
// Back end: palette memory, sequential match scan, append and result register
module ucpb_scan #(
  parameter int unsigned ENTRIES = ucpb_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ucpb_pkg::pix_t     q_pix,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ucpb_pkg::out_item_t out_item
);
  import ucpb_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  logic [23:0]   mem [ENTRIES];
  logic [23:0]   rd_data_r;

  state_t        state_r, state_nxt;
  pix_t          pix_r, pix_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          full_r, full_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  out_item_t     res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;
  logic          wr_en;
  logic          out_free;
  logic          match;
  logic          miss;
  logic          room;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign match     = chk_vld_r && (rd_data_r == pix_r.colour);
  assign miss      = !chk_vld_r && (k_r >= cnt_r);
  assign room      = cnt_r < CW'(ENTRIES);

  always_comb begin
    state_nxt     = state_r;
    pix_nxt       = pix_r;
    cnt_nxt       = cnt_r;
    full_nxt      = full_r;
    k_nxt         = k_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          pix_nxt     = q_pix;
          k_nxt       = '0;
          chk_vld_nxt = 1'b0;
          if (q_pix.first) begin
            cnt_nxt  = '0;
            full_nxt = 1'b0;
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match || miss) begin
          res_nxt.is_new      = 1'b0;
          res_nxt.color_index = 8'(chk_idx_r);
          if (!match) begin
            res_nxt.color_index = '0;
            if (!full_r && room) begin
              wr_en               = 1'b1;
              res_nxt.color_index = 8'(cnt_r[IW-1:0]);
              res_nxt.is_new      = 1'b1;
              cnt_nxt             = cnt_r + CW'(1);
            end else if (!full_r) begin
              full_nxt = 1'b1;
            end
          end
          res_nxt.overflowed   = full_nxt;
          res_nxt.color_count  = 9'(cnt_nxt);
          res_nxt.image_done   = pix_r.last;
          res_nxt.build_failed = pix_r.last && (full_nxt || cnt_nxt == CW'(ENTRIES));
          chk_vld_nxt          = 1'b0;
          state_nxt            = ST_DONE;
        end else if (k_r < cnt_r) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = k_r[IW-1:0];
          k_nxt       = k_r + CW'(1);
        end else begin
          chk_vld_nxt = 1'b0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      full_r      <= 1'b0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      full_r      <= full_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r     <= pix_nxt;
    k_r       <= k_nxt;
    chk_idx_r <= chk_idx_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[IW-1:0]] <= pix_r.colour;
    end
    rd_data_r <= mem[k_r[IW-1:0]];
  end

endmodule
